[rtl/core/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers for the window statistics core.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising clock edge outside reset.
`define SWM_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Expression must never be true outside reset.
`define SWM_ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
  `SWM_ASSERT(lbl, clk, rst_n, !(expr), msg)

`endif

[rtl/core/swmmm_pkg.sv]
// ----------------------------------------------------------------------------
// swmmm_pkg
// Shared constants and controller/datapath interface types.
// ----------------------------------------------------------------------------
`default_nettype none

package swmmm_pkg;

  localparam int WindowMaxDef  = 256;
  localparam int SampleBitsDef = 16;
  localparam int LenBits       = 9;   // width of the window length write data
  localparam int LenReset      = 16;  // window length after reset

  // controller -> datapath
  typedef struct packed {
    logic accept;     // sample transfer: latch sample, fold into max/min, read oldest entry
    logic update;     // store write, sum update, pointer advance
    logic scan_rd;    // one rescan read
    logic div_start;  // launch average division
    logic out_load;   // capture result registers
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic full;       // window holds window_length samples
    logic old_hit;    // evicted sample equals max or min
    logic scan_last;  // rescan read of the final entry
  } status_t;

endpackage

`default_nettype wire

[rtl/core/swmmm_div.sv]
// ----------------------------------------------------------------------------
// swmmm_div
// Restoring divider, one quotient bit per cycle, truncating toward zero.
// ----------------------------------------------------------------------------
`default_nettype none

module swmmm_div #(
  parameter int SumBits    = 24,
  parameter int CntBits    = 9,
  parameter int SampleBits = 16
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start_i,
  input  wire logic signed [SumBits-1:0]    dividend_i,
  input  wire logic        [CntBits-1:0]    divisor_i,
  output logic                              done_o,
  output logic signed [SampleBits-1:0]      quotient_o
);

  localparam int StepBits = $clog2(SumBits + 1);

  logic                busy_q;
  logic                done_q;
  logic [StepBits-1:0] step_q;
  logic [SumBits-1:0]  acc_q;
  logic [CntBits-1:0]  rem_q;
  logic [CntBits-1:0]  div_q;
  logic                neg_q;

  logic [CntBits:0]    rem_sh;
  logic [CntBits:0]    rem_sub;
  logic                qbit;
  logic [SumBits-1:0]  mag;
  logic [SumBits-1:0]  quot;

  assign mag     = dividend_i[SumBits-1] ? (~dividend_i + 1'b1) : dividend_i;
  assign rem_sh  = {rem_q, acc_q[SumBits-1]};
  assign rem_sub = rem_sh - {1'b0, div_q};
  assign qbit    = (rem_sh >= {1'b0, div_q});
  assign quot    = neg_q ? (~acc_q + 1'b1) : acc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      step_q <= StepBits'(SumBits);
    end else if (busy_q) begin
      step_q <= step_q - 1'b1;
      if (step_q == StepBits'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      acc_q <= mag;
      rem_q <= '0;
      div_q <= divisor_i;
      neg_q <= dividend_i[SumBits-1];
    end else if (busy_q) begin
      acc_q <= {acc_q[SumBits-2:0], qbit};
      rem_q <= qbit ? rem_sub[CntBits-1:0] : rem_sh[CntBits-1:0];
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quot[SampleBits-1:0];

endmodule

`default_nettype wire

[rtl/core/swmmm_ctrl.sv]
// ----------------------------------------------------------------------------
// swmmm_ctrl
// Sequencer: transfer, store update, optional rescan, division, result.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module swmmm_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  input  wire swmmm_pkg::status_t status_i,
  input  wire logic               div_done_i,
  output swmmm_pkg::cmd_t         cmd_o
);

  typedef enum logic [2:0] {
    StIdle,
    StUpdate,
    StScan,
    StDrain,
    StDiv,
    StWait,
    StDone
  } state_e;

  state_e          state_q;
  state_e          state_d;
  logic            out_vld_q;
  swmmm_pkg::cmd_t cmd;

  always_comb begin
    state_d = state_q;
    cmd     = '0;
    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd.accept = 1'b1;
          state_d    = StUpdate;
        end
      end
      StUpdate: begin
        cmd.update = 1'b1;
        state_d    = (status_i.full && status_i.old_hit) ? StScan : StDiv;
      end
      StScan: begin
        cmd.scan_rd = 1'b1;
        if (status_i.scan_last) begin
          state_d = StDrain;
        end
      end
      StDrain: begin
        state_d = StDiv;
      end
      StDiv: begin
        cmd.div_start = 1'b1;
        state_d       = StWait;
      end
      StWait: begin
        if (div_done_i) begin
          state_d = StDone;
        end
      end
      StDone: begin
        if (!out_vld_q || out_ready_i) begin
          cmd.out_load = 1'b1;
          state_d      = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cmd.out_load) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = out_vld_q;
  assign cmd_o       = cmd;

  // a pending result is never overwritten
  `SWM_ASSERT(a_no_overwrite, clk_i, rst_ni,
              cmd.out_load |-> (!out_vld_q || out_ready_i), "result overwritten")
  // divider finishes only while we wait for it
  `SWM_ASSERT(a_done_in_wait, clk_i, rst_ni,
              div_done_i |-> (state_q == StWait), "unexpected divider done")

endmodule

`default_nettype wire

[rtl/core/swmmm_dp.sv]
// ----------------------------------------------------------------------------
// swmmm_dp
// Sample ring store, running sum, max/min tracking and result registers.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module swmmm_dp #(
  parameter int WindowMax  = 256,
  parameter int SampleBits = 16,
  parameter int SumBits    = 24,
  parameter int CntBits    = 9
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 cfg_we_i,
  input  wire logic [swmmm_pkg::LenBits-1:0]        cfg_wdata_i,
  input  wire logic signed [SampleBits-1:0]         sample_i,
  input  wire swmmm_pkg::cmd_t                      cmd_i,
  output swmmm_pkg::status_t                        status_o,
  output logic signed [SumBits-1:0]                 sum_o,
  output logic [CntBits-1:0]                        held_o,
  input  wire logic signed [SampleBits-1:0]         quotient_i,
  output logic signed [SampleBits-1:0]              highest_o,
  output logic signed [SampleBits-1:0]              lowest_o,
  output logic signed [SampleBits-1:0]              average_o
);

  localparam int IdxBits = (WindowMax > 1) ? $clog2(WindowMax) : 1;
  localparam int CmpBits = ((CntBits > swmmm_pkg::LenBits) ? CntBits
                                                          : swmmm_pkg::LenBits) + 1;
  localparam logic signed [SampleBits-1:0] SampleMin = {1'b1, {(SampleBits-1){1'b0}}};
  localparam logic signed [SampleBits-1:0] SampleMax = {1'b0, {(SampleBits-1){1'b1}}};

  // zero means one, anything beyond the store saturates
  function automatic logic [CntBits-1:0] clamp_len(input logic [swmmm_pkg::LenBits-1:0] v);
    logic [CntBits-1:0] r;
    if (v == '0) begin
      r = CntBits'(1);
    end else if (CmpBits'(v) > CmpBits'(WindowMax)) begin
      r = CntBits'(WindowMax);
    end else begin
      r = CntBits'(v);
    end
    return r;
  endfunction

  logic [CntBits-1:0]              len_q;
  logic [CntBits-1:0]              held_q;
  logic [IdxBits-1:0]              oldest_q;
  logic [IdxBits-1:0]              scan_q;
  logic                            scan_vld_q;
  logic signed [SumBits-1:0]       sum_q;
  logic signed [SampleBits-1:0]    max_q;
  logic signed [SampleBits-1:0]    min_q;
  logic signed [SampleBits-1:0]    sample_q;
  logic signed [SampleBits-1:0]    rdata_q;
  logic signed [SampleBits-1:0]    mem [WindowMax];

  logic                            full;
  logic                            old_hit;
  logic [IdxBits-1:0]              waddr;
  logic [IdxBits-1:0]              raddr;
  logic                            rd_en;
  logic [IdxBits-1:0]              oldest_nxt;

  assign full       = (held_q == len_q);
  assign old_hit    = (rdata_q == max_q) || (rdata_q == min_q);
  assign waddr      = full ? oldest_q : held_q[IdxBits-1:0];
  assign rd_en      = cmd_i.accept || cmd_i.scan_rd;
  assign raddr      = cmd_i.scan_rd ? scan_q : oldest_q;
  assign oldest_nxt = (CntBits'(oldest_q) == len_q - 1'b1) ? '0 : oldest_q + 1'b1;

  // ring store, registered read
  always_ff @(posedge clk_i) begin
    if (cmd_i.update) begin
      mem[waddr] <= sample_q;
    end
    if (rd_en) begin
      rdata_q <= mem[raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      sample_q <= sample_i;
    end
    if (cmd_i.out_load) begin
      highest_o <= max_q;
      lowest_o  <= min_q;
      average_o <= quotient_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q      <= clamp_len(swmmm_pkg::LenBits'(swmmm_pkg::LenReset));
      held_q     <= '0;
      oldest_q   <= '0;
      sum_q      <= '0;
      max_q      <= SampleMin;
      min_q      <= SampleMax;
      scan_q     <= '0;
      scan_vld_q <= 1'b0;
    end else if (cfg_we_i) begin
      len_q    <= clamp_len(cfg_wdata_i);
      held_q   <= '0;
      oldest_q <= '0;
      sum_q    <= '0;
      max_q    <= SampleMin;
      min_q    <= SampleMax;
    end else begin
      scan_vld_q <= cmd_i.scan_rd;
      if (cmd_i.accept) begin
        if (sample_i > max_q) max_q <= sample_i;
        if (sample_i < min_q) min_q <= sample_i;
      end
      if (cmd_i.update) begin
        if (full) begin
          sum_q    <= sum_q - SumBits'(rdata_q) + SumBits'(sample_q);
          oldest_q <= oldest_nxt;
          if (old_hit) begin
            max_q  <= SampleMin;
            min_q  <= SampleMax;
            scan_q <= '0;
          end
        end else begin
          sum_q  <= sum_q + SumBits'(sample_q);
          held_q <= held_q + 1'b1;
        end
      end
      if (cmd_i.scan_rd) begin
        scan_q <= scan_q + 1'b1;
      end
      if (scan_vld_q) begin
        if (rdata_q > max_q) max_q <= rdata_q;
        if (rdata_q < min_q) min_q <= rdata_q;
      end
    end
  end

  assign status_o.full      = full;
  assign status_o.old_hit   = old_hit;
  assign status_o.scan_last = (CntBits'(scan_q) == len_q - 1'b1);
  assign sum_o              = sum_q;
  assign held_o             = held_q;

  `SWM_ASSERT(a_held_le_len, clk_i, rst_ni, held_q <= len_q, "fill count beyond window")
  `SWM_ASSERT(a_oldest_in_len, clk_i, rst_ni,
              CntBits'(oldest_q) < len_q, "ring pointer beyond window")

endmodule

`default_nettype wire

[rtl/core/sliding_window_min_max_mean_unit.sv]
// ----------------------------------------------------------------------------
// sliding_window_min_max_mean_unit
// Max, min and truncated mean over the most recent window_length samples.
// ----------------------------------------------------------------------------
//
//  channel  | handshake                        | payload
//  ---------+----------------------------------+------------------------------
//  sample   | sample_valid_i / sample_ready_o  | sample_i
//  result   | result_valid_o / result_ready_i  | highest_o, lowest_o, average_o
//  config   | cfg_we_i (no wait)               | cfg_wdata_i (window length)
//
//  Each sample passes a transfer, a store update, the divider handoff and
//  division, and the result load; when the evicted sample was the current
//  max or min, a rescan of all window_length entries comes before the
//  division, reading the ring store one entry per cycle.
//  Reset clears the window and sets window_length to 16; the store itself
//  is not cleared, and read data of an entry is used only after it is written.
//  A finished result sits in the output register; the next sample transfer
//  is taken while it waits, and only the result load stalls on result_ready_i.
//  A window length write clears the window immediately.
// ----------------------------------------------------------------------------
`default_nettype none

module sliding_window_min_max_mean_unit #(
  parameter int WindowMax  = swmmm_pkg::WindowMaxDef,
  parameter int SampleBits = swmmm_pkg::SampleBitsDef
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  // configuration
  input  wire logic                             cfg_we_i,
  input  wire logic [swmmm_pkg::LenBits-1:0]    cfg_wdata_i,
  // sample input
  input  wire logic                             sample_valid_i,
  output logic                                  sample_ready_o,
  input  wire logic signed [SampleBits-1:0]     sample_i,
  // result output
  output logic                                  result_valid_o,
  input  wire logic                             result_ready_i,
  output logic signed [SampleBits-1:0]          highest_o,
  output logic signed [SampleBits-1:0]          lowest_o,
  output logic signed [SampleBits-1:0]          average_o
);

  // fill count must hold WindowMax itself; sum grows by log2 of the window
  localparam int CntBits = $clog2(WindowMax + 1);
  localparam int SumBits = SampleBits + $clog2(WindowMax);

  swmmm_pkg::cmd_t            cmd;
  swmmm_pkg::status_t         status;
  logic                       div_done;
  logic signed [SumBits-1:0]  sum;
  logic [CntBits-1:0]         held;
  logic signed [SampleBits-1:0] quotient;

  // sequencer
  swmmm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (sample_valid_i),
    .in_ready_o  (sample_ready_o),
    .out_valid_o (result_valid_o),
    .out_ready_i (result_ready_i),
    .status_i    (status),
    .div_done_i  (div_done),
    .cmd_o       (cmd)
  );

  // ring store, sum, max/min, result registers
  swmmm_dp #(
    .WindowMax  (WindowMax),
    .SampleBits (SampleBits),
    .SumBits    (SumBits),
    .CntBits    (CntBits)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .sample_i    (sample_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .sum_o       (sum),
    .held_o      (held),
    .quotient_i  (quotient),
    .highest_o   (highest_o),
    .lowest_o    (lowest_o),
    .average_o   (average_o)
  );

  // mean = sum / samples held, one quotient bit per cycle
  swmmm_div #(
    .SumBits    (SumBits),
    .CntBits    (CntBits),
    .SampleBits (SampleBits)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd.div_start),
    .dividend_i (sum),
    .divisor_i  (held),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

endmodule

`default_nettype wire
